// ----- sv/dma_channel_sequencer_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DMA_CHANNEL_SEQUENCER_CORE_DEFINES_SVH
`define DMA_CHANNEL_SEQUENCER_CORE_DEFINES_SVH

`define DCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcs check failed");

`define DCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcs check failed");

`endif

// ----- sv/dcs_pkg.sv -----
package dcs_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int CH_W = 3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_HEAD  = 2'd3;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BLOCK = 3'd1;
    localparam logic [2:0] PH_LHEAD = 3'd2;
    localparam logic [2:0] PH_LLATCH = 3'd3;
    localparam logic [2:0] PH_LBODY = 3'd4;

    localparam logic [2:0] CH_GLOBAL = 3'd7;
    localparam logic [2:0] CH_GPU    = 3'd2;
    localparam logic [2:0] CH_OTC    = 3'd6;

    localparam logic [1:0] SEL_BASE  = 2'd0;
    localparam logic [1:0] SEL_BLOCK = 2'd1;
    localparam logic [1:0] SEL_CTRL  = 2'd2;

    localparam logic [1:0] SEL_PRIMARY = 2'd0;
    localparam logic [1:0] SEL_IRQ     = 2'd1;

    localparam logic [31:0] ADDR_MASK   = 32'h001ffffc;
    localparam logic [31:0] OTC_END     = 32'h00ffffff;
    localparam logic [31:0] OTC_MASK    = 32'h001fffff;
    localparam logic [31:0] PRIMARY_RST = 32'h07654321;

    typedef struct packed {
        logic [1:0]  op_kind;
        logic [20:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [31:0] read_data;
        logic        busy_res;
        logic        done_now;
        logic        fault;
        logic        irq_out;
    } t_result;

endpackage

// ----- sv/dma_channel_sequencer_core.sv -----
// Results go to the result register, or the skid register while the output stalls.
// One command per cycle while o_stall is low; all work happens in one registered
// pass. A two-entry output (result register plus skid register) lets input continue
// while a result waits. Synchronous active-low reset clears the controller state and
// both output valid flags, and the primary control register resets to 0x07654321.
module dma_channel_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_channel,
    input  logic [1:0]  i_reg_select,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_mem_word,
    input  logic [31:0] i_gpu_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_op_kind,
    output logic [20:0] o_mem_addr,
    output logic [31:0] o_mem_wdata,
    output logic [31:0] o_read_data,
    output logic        o_busy_res,
    output logic        o_done_now,
    output logic        o_fault,
    output logic        o_irq_out
);

    localparam int NCH = dcs_pkg::NUM_CHANNELS;
    localparam int CW = dcs_pkg::CH_W;

    logic [31:0] r_base [NCH];
    logic [31:0] r_block [NCH];
    logic [5:0]  r_ctrl [NCH];
    logic [6:0]  r_irq_en;
    logic [6:0]  r_irq_flags;
    logic [1:0]  r_irq_fm;
    logic [31:0] r_primary;
    logic [CW-1:0] r_active;
    logic [2:0]  r_phase;
    logic [31:0] r_cur;
    logic [31:0] r_left;
    logic [31:0] r_header;

    logic [31:0] n_base [NCH];
    logic [31:0] n_block [NCH];
    logic [5:0]  n_ctrl [NCH];
    logic [6:0]  n_irq_en;
    logic [6:0]  n_irq_flags;
    logic [1:0]  n_irq_fm;
    logic [31:0] n_primary;
    logic [CW-1:0] n_active;
    logic [2:0]  n_phase;
    logic [31:0] n_cur;
    logic [31:0] n_left;
    logic [31:0] n_header;

    dcs_pkg::t_result n_res;
    dcs_pkg::t_result r_out;
    dcs_pkg::t_result r_skid;
    logic r_out_v;
    logic r_skid_v;
    logic accept;

    assign o_stall = r_skid_v;
    assign accept = i_valid && !r_skid_v;

    always_comb begin
        logic [CW-1:0] ch;
        logic [CW-1:0] ac;
        logic          busy;
        logic [31:0]   a;
        logic [31:0]   stp;
        logic [31:0]   sz;
        logic [1:0]    syn;
        logic          to_ram;
        logic          do_complete;
        logic [CW-1:0] cc;
        logic [31:0]   rdata;
        logic [1:0]    op;
        logic [31:0]   addr;
        logic [31:0]   wdata;
        logic          done;
        logic          flt;
        n_base = r_base;
        n_block = r_block;
        n_ctrl = r_ctrl;
        n_irq_en = r_irq_en;
        n_irq_flags = r_irq_flags;
        n_irq_fm = r_irq_fm;
        n_primary = r_primary;
        n_active = r_active;
        n_phase = r_phase;
        n_cur = r_cur;
        n_left = r_left;
        n_header = r_header;
        ch = i_channel;
        ac = r_active;
        busy = r_phase != dcs_pkg::PH_IDLE;
        a = '0;
        stp = '0;
        sz = '0;
        syn = '0;
        to_ram = 1'b0;
        do_complete = 1'b0;
        cc = r_active;
        rdata = '0;
        op = dcs_pkg::OP_NONE;
        addr = '0;
        wdata = '0;
        done = 1'b0;
        flt = 1'b0;

        if (i_command == dcs_pkg::CMD_WRITE) begin
            if (ch == dcs_pkg::CH_GLOBAL) begin
                if (i_reg_select == dcs_pkg::SEL_PRIMARY) begin
                    n_primary = i_write_data;
                end else if (i_reg_select == dcs_pkg::SEL_IRQ) begin
                    n_irq_fm = {i_write_data[23], i_write_data[15]};
                    n_irq_en = i_write_data[22:16];
                    n_irq_flags = r_irq_flags & ~i_write_data[30:24];
                end
            end else if (32'(ch) < 32'(NCH)) begin
                if (i_reg_select == dcs_pkg::SEL_BASE) begin
                    n_base[ch] = i_write_data;
                end else if (i_reg_select == dcs_pkg::SEL_BLOCK) begin
                    n_block[ch] = i_write_data;
                end else if (i_reg_select == dcs_pkg::SEL_CTRL && !(busy && r_active == ch)) begin
                    n_ctrl[ch] = {i_write_data[28], i_write_data[24], i_write_data[10:9],
                                  i_write_data[1:0]};
                    syn = n_ctrl[ch][3:2];
                    if (!busy && n_ctrl[ch][4] && (syn != 2'd0 || n_ctrl[ch][5])) begin
                        to_ram = !n_ctrl[ch][0];
                        n_active = ch;
                        if (syn == 2'd2) begin
                            if (ch != dcs_pkg::CH_GPU || to_ram) begin
                                flt = 1'b1;
                                n_ctrl[ch] = {2'b00, n_ctrl[ch][3:0]};
                            end else begin
                                n_cur = r_base[ch];
                                n_phase = dcs_pkg::PH_LHEAD;
                            end
                        end else begin
                            if (syn == 2'd0) begin
                                sz = {16'd0, r_block[ch][15:0]};
                            end else if (syn == 2'd1) begin
                                sz = r_block[ch][15:0] * r_block[ch][31:16];
                            end
                            n_cur = r_base[ch];
                            if (sz == 32'd0) begin
                                do_complete = 1'b1;
                                cc = ch;
                                done = 1'b1;
                            end else if (!(ch == dcs_pkg::CH_GPU
                                           || (to_ram && ch == dcs_pkg::CH_OTC))) begin
                                flt = 1'b1;
                                n_ctrl[ch] = {2'b00, n_ctrl[ch][3:0]};
                            end else begin
                                n_left = sz;
                                n_phase = dcs_pkg::PH_BLOCK;
                            end
                        end
                    end
                end
            end
        end else if (i_command == dcs_pkg::CMD_READ) begin
            if (ch == dcs_pkg::CH_GLOBAL) begin
                if (i_reg_select == dcs_pkg::SEL_PRIMARY) begin
                    rdata = r_primary;
                end else if (i_reg_select == dcs_pkg::SEL_IRQ) begin
                    rdata = {(r_irq_fm[0] || (r_irq_fm[1] && (r_irq_en & r_irq_flags) != '0)),
                             r_irq_flags, r_irq_fm[1], r_irq_en, r_irq_fm[0], 15'd0};
                end
            end else if (32'(ch) < 32'(NCH)) begin
                if (i_reg_select == dcs_pkg::SEL_BASE) begin
                    rdata = r_base[ch];
                end else if (i_reg_select == dcs_pkg::SEL_BLOCK) begin
                    rdata = r_block[ch];
                end else if (i_reg_select == dcs_pkg::SEL_CTRL) begin
                    rdata = {3'd0, r_ctrl[ch][5], 3'd0, r_ctrl[ch][4], 13'd0, r_ctrl[ch][3:2],
                             7'd0, r_ctrl[ch][1:0]};
                end
            end
        end else if (i_command == dcs_pkg::CMD_STEP && busy) begin
            stp = r_ctrl[ac][1] ? 32'hfffffffc : 32'd4;
            if (r_phase == dcs_pkg::PH_BLOCK) begin
                a = r_cur & dcs_pkg::ADDR_MASK;
                addr = a;
                if (!r_ctrl[ac][0]) begin
                    op = dcs_pkg::OP_WRITE;
                    if (ac == dcs_pkg::CH_OTC) begin
                        wdata = (r_left == 32'd1) ? dcs_pkg::OTC_END
                                                  : ((a - 32'd4) & dcs_pkg::OTC_MASK);
                    end else begin
                        wdata = i_gpu_word;
                    end
                end else begin
                    op = dcs_pkg::OP_READ;
                end
                n_cur = a + stp;
                n_left = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    do_complete = 1'b1;
                    done = 1'b1;
                end
            end else if (r_phase == dcs_pkg::PH_LHEAD) begin
                n_cur = r_cur & dcs_pkg::ADDR_MASK;
                op = dcs_pkg::OP_HEAD;
                addr = n_cur;
                n_phase = dcs_pkg::PH_LLATCH;
            end else begin
                if (r_phase == dcs_pkg::PH_LLATCH) begin
                    n_header = i_mem_word;
                    n_left = {24'd0, i_mem_word[31:24]};
                    n_phase = dcs_pkg::PH_LBODY;
                end
                if (n_left != 32'd0) begin
                    n_cur = (r_cur + 32'd4) & dcs_pkg::ADDR_MASK;
                    op = dcs_pkg::OP_READ;
                    addr = n_cur;
                    n_left = n_left - 32'd1;
                end else if (n_header[23]) begin
                    do_complete = 1'b1;
                    done = 1'b1;
                end else begin
                    n_cur = n_header & dcs_pkg::ADDR_MASK;
                    op = dcs_pkg::OP_HEAD;
                    addr = n_cur;
                    n_phase = dcs_pkg::PH_LLATCH;
                end
            end
        end

        if (do_complete) begin
            stp = n_ctrl[cc][1] ? 32'hfffffffc : 32'd4;
            if (n_ctrl[cc][3:2] == 2'd1) begin
                n_base[cc] = n_cur - stp;
            end
            n_ctrl[cc] = {2'b00, n_ctrl[cc][3:0]};
            if (n_irq_en[cc]) begin
                n_irq_flags[cc] = 1'b1;
            end
            n_phase = dcs_pkg::PH_IDLE;
        end

        n_res.op_kind = op;
        n_res.mem_addr = addr[20:0];
        n_res.mem_wdata = wdata;
        n_res.read_data = rdata;
        n_res.busy_res = n_phase != dcs_pkg::PH_IDLE;
        n_res.done_now = done;
        n_res.fault = flt;
        n_res.irq_out = n_irq_fm[0] || (n_irq_fm[1] && (n_irq_en & n_irq_flags) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCH; k++) begin
                r_base[k] <= '0;
                r_block[k] <= '0;
                r_ctrl[k] <= '0;
            end
            r_irq_en <= '0;
            r_irq_flags <= '0;
            r_irq_fm <= '0;
            r_primary <= dcs_pkg::PRIMARY_RST;
            r_active <= '0;
            r_phase <= dcs_pkg::PH_IDLE;
            r_cur <= '0;
            r_left <= '0;
            r_header <= '0;
        end else if (accept) begin
            r_base <= n_base;
            r_block <= n_block;
            r_ctrl <= n_ctrl;
            r_irq_en <= n_irq_en;
            r_irq_flags <= n_irq_flags;
            r_irq_fm <= n_irq_fm;
            r_primary <= n_primary;
            r_active <= n_active;
            r_phase <= n_phase;
            r_cur <= n_cur;
            r_left <= n_left;
            r_header <= n_header;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= r_skid_v || accept;
            r_skid_v <= 1'b0;
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_op_kind = r_out.op_kind;
    assign o_mem_addr = r_out.mem_addr;
    assign o_mem_wdata = r_out.mem_wdata;
    assign o_read_data = r_out.read_data;
    assign o_busy_res = r_out.busy_res;
    assign o_done_now = r_out.done_now;
    assign o_fault = r_out.fault;
    assign o_irq_out = r_out.irq_out;

endmodule

// ----- sv/dcs_checker.sv -----
`include "dma_channel_sequencer_core_defines.svh"

module dcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_op_kind,
    input logic [20:0] o_mem_addr,
    input logic [31:0] o_mem_wdata,
    input logic        o_done_now,
    input logic        o_busy_res
);

    `DCS_ASSERT_NOW(a_stall_needs_result, o_stall, o_valid)
    `DCS_ASSERT_NEXT(a_held_result_stays, o_valid && i_stall, o_valid)
    `DCS_ASSERT_NOW(a_idle_op_quiet, o_valid && o_op_kind == dcs_pkg::OP_NONE,
        o_mem_addr == 21'd0 && o_mem_wdata == 32'd0)
    `DCS_ASSERT_NOW(a_done_not_busy, o_valid && o_done_now, !o_busy_res)

endmodule

bind dma_channel_sequencer_core dcs_checker u_dcs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_op_kind(o_op_kind),
    .o_mem_addr(o_mem_addr),
    .o_mem_wdata(o_mem_wdata),
    .o_done_now(o_done_now),
    .o_busy_res(o_busy_res)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NOP     = 2'd3;
    localparam logic [1:0] SEL_UNUSED  = 2'd3;
    localparam logic [2:0] CH_ZERO     = 3'd0;
    localparam logic [2:0] CH_ONE      = 3'd1;
    localparam logic [2:0] CH_FIVE     = 3'd5;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;

    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  ch;
        logic [1:0]  sel;
        logic [31:0] wd;
        logic [31:0] mw;
        logic [31:0] gw;
        bit          typed;
        logic [31:0] typed_rdata;
        logic        typed_fault;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_NOP;
    logic [2:0]  i_channel = '0;
    logic [1:0]  i_reg_select = '0;
    logic [31:0] i_write_data = '0;
    logic [31:0] i_mem_word = '0;
    logic [31:0] i_gpu_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_op_kind;
    logic [20:0] o_mem_addr;
    logic [31:0] o_mem_wdata;
    logic [31:0] o_read_data;
    logic        o_busy_res;
    logic        o_done_now;
    logic        o_fault;
    logic        o_irq_out;

    dma_channel_sequencer_core dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the controller state.
    logic [31:0] chan_base [dcs_pkg::NUM_CHANNELS];
    logic [31:0] chan_block [dcs_pkg::NUM_CHANNELS];
    logic [5:0]  chan_ctl [dcs_pkg::NUM_CHANNELS];
    logic [6:0]  irq_en;
    logic [6:0]  irq_flag;
    logic [1:0]  irq_fm;
    logic [31:0] prim_reg;
    logic [2:0]  run_ch;
    logic [2:0]  run_phase;
    logic [31:0] run_addr;
    logic [31:0] run_left;
    logic [31:0] run_hdr;

    t_item   stim_q[$];
    dcs_pkg::t_result result_q[$];
    logic    cur_typed = 1'b0;
    logic [31:0] cur_rdata = '0;
    logic    cur_fault = 1'b0;
    int      err_cnt = 0;
    bit      hold_req = 0;
    int      idle_cnt = 0;

    function automatic logic [31:0] irq_word();
        logic [31:0] v;
        v = {1'b0, irq_flag, irq_fm[1], irq_en, irq_fm[0], 15'd0};
        if (irq_fm[0] || (irq_fm[1] && (irq_en & irq_flag) != 0)) v[31] = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] stride(logic [2:0] ch);
        return chan_ctl[ch][1] ? 32'hfffffffc : 32'd4;
    endfunction

    function automatic void finish_xfer(logic [2:0] ch);
        if (chan_ctl[ch][3:2] == 2'd1) chan_base[ch] = run_addr - stride(ch);
        chan_ctl[ch][5:4] = 2'b00;
        if (irq_en[ch]) irq_flag[ch] = 1'b1;
        run_phase = dcs_pkg::PH_IDLE;
    endfunction

    function automatic dcs_pkg::t_result predict_dma(t_item it);
        dcs_pkg::t_result r;
        logic busy, to_ram;
        logic [1:0] sync;
        logic [31:0] size, a, irq;
        r = '0;
        if (it.cmd == dcs_pkg::CMD_WRITE) begin
            if (it.ch == dcs_pkg::CH_GLOBAL) begin
                if (it.sel == dcs_pkg::SEL_PRIMARY) begin
                    prim_reg = it.wd;
                end else if (it.sel == dcs_pkg::SEL_IRQ) begin
                    irq_fm = {it.wd[23], it.wd[15]};
                    irq_en = it.wd[22:16];
                    irq_flag &= ~it.wd[30:24];
                end
            end else begin
                busy = run_phase != dcs_pkg::PH_IDLE;
                if (it.sel == dcs_pkg::SEL_BASE) begin
                    chan_base[it.ch] = it.wd;
                end else if (it.sel == dcs_pkg::SEL_BLOCK) begin
                    chan_block[it.ch] = it.wd;
                end else if (it.sel == dcs_pkg::SEL_CTRL && !(busy && run_ch == it.ch)) begin
                    chan_ctl[it.ch] = {it.wd[28], it.wd[24], it.wd[10:9], it.wd[1:0]};
                    sync = chan_ctl[it.ch][3:2];
                    if (!busy && chan_ctl[it.ch][4] && (sync != 2'd0 || chan_ctl[it.ch][5]))
                    begin
                        to_ram = !chan_ctl[it.ch][0];
                        run_ch = it.ch;
                        if (sync == 2'd2) begin
                            if (it.ch != dcs_pkg::CH_GPU || to_ram) begin
                                r.fault = 1'b1;
                                chan_ctl[it.ch][5:4] = 2'b00;
                            end else begin
                                run_addr = chan_base[it.ch];
                                run_phase = dcs_pkg::PH_LHEAD;
                            end
                        end else begin
                            size = sync == 2'd0 ? {16'd0, chan_block[it.ch][15:0]} :
                                   sync == 2'd1 ? chan_block[it.ch][15:0] *
                                                  chan_block[it.ch][31:16] : 32'd0;
                            run_addr = chan_base[it.ch];
                            if (size == 0) begin
                                finish_xfer(it.ch);
                                r.done_now = 1'b1;
                            end else if (!(it.ch == dcs_pkg::CH_GPU ||
                                           (to_ram && it.ch == dcs_pkg::CH_OTC))) begin
                                r.fault = 1'b1;
                                chan_ctl[it.ch][5:4] = 2'b00;
                            end else begin
                                run_left = size;
                                run_phase = dcs_pkg::PH_BLOCK;
                            end
                        end
                    end
                end
            end
        end else if (it.cmd == dcs_pkg::CMD_READ) begin
            if (it.ch == dcs_pkg::CH_GLOBAL) begin
                if (it.sel == dcs_pkg::SEL_PRIMARY) r.read_data = prim_reg;
                else if (it.sel == dcs_pkg::SEL_IRQ) r.read_data = irq_word();
            end else begin
                if (it.sel == dcs_pkg::SEL_BASE) r.read_data = chan_base[it.ch];
                else if (it.sel == dcs_pkg::SEL_BLOCK) r.read_data = chan_block[it.ch];
                else if (it.sel == dcs_pkg::SEL_CTRL)
                    r.read_data = {3'd0, chan_ctl[it.ch][5], 3'd0, chan_ctl[it.ch][4], 13'd0,
                                   chan_ctl[it.ch][3:2], 7'd0, chan_ctl[it.ch][1:0]};
            end
        end else if (it.cmd == dcs_pkg::CMD_STEP && run_phase != dcs_pkg::PH_IDLE) begin
            if (run_phase == dcs_pkg::PH_BLOCK) begin
                a = run_addr & dcs_pkg::ADDR_MASK;
                r.mem_addr = a[20:0];
                if (!chan_ctl[run_ch][0]) begin
                    r.op_kind = dcs_pkg::OP_WRITE;
                    if (run_ch == dcs_pkg::CH_OTC)
                        r.mem_wdata = run_left == 1 ? dcs_pkg::OTC_END
                                                    : ((a - 4) & dcs_pkg::OTC_MASK);
                    else
                        r.mem_wdata = it.gw;
                end else begin
                    r.op_kind = dcs_pkg::OP_READ;
                end
                run_addr = a + stride(run_ch);
                run_left = run_left - 1;
                if (run_left == 0) begin
                    finish_xfer(run_ch);
                    r.done_now = 1'b1;
                end
            end else if (run_phase == dcs_pkg::PH_LHEAD) begin
                run_addr &= dcs_pkg::ADDR_MASK;
                r.op_kind = dcs_pkg::OP_HEAD;
                r.mem_addr = run_addr[20:0];
                run_phase = dcs_pkg::PH_LLATCH;
            end else begin
                if (run_phase == dcs_pkg::PH_LLATCH) begin
                    run_hdr = it.mw;
                    run_left = {24'd0, it.mw[31:24]};
                    run_phase = dcs_pkg::PH_LBODY;
                end
                if (run_left != 0) begin
                    run_addr = (run_addr + 4) & dcs_pkg::ADDR_MASK;
                    r.op_kind = dcs_pkg::OP_READ;
                    r.mem_addr = run_addr[20:0];
                    run_left = run_left - 1;
                end else if (run_hdr[23]) begin
                    finish_xfer(run_ch);
                    r.done_now = 1'b1;
                end else begin
                    run_addr = run_hdr & dcs_pkg::ADDR_MASK;
                    r.op_kind = dcs_pkg::OP_HEAD;
                    r.mem_addr = run_addr[20:0];
                    run_phase = dcs_pkg::PH_LLATCH;
                end
            end
        end
        r.busy_res = run_phase != dcs_pkg::PH_IDLE;
        irq = irq_word();
        r.irq_out = irq[31];
        return r;
    endfunction

    always @(posedge i_clk) begin
        dcs_pkg::t_result got, want;
        t_item it;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_op_kind, o_mem_addr, o_mem_wdata, o_read_data,
                        o_busy_res, o_done_now, o_fault, o_irq_out};
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected result %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got.op_kind !== want.op_kind || got.mem_addr !== want.mem_addr ||
                        got.mem_wdata !== want.mem_wdata || got.read_data !== want.read_data ||
                        got.busy_res !== want.busy_res || got.done_now !== want.done_now ||
                        got.fault !== want.fault || got.irq_out !== want.irq_out) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                it = '{i_command, i_channel, i_reg_select, i_write_data, i_mem_word,
                       i_gpu_word, 1'b0, '0, 1'b0};
                want = predict_dma(it);
                if (cur_typed) begin
                    want.read_data = cur_rdata;
                    want.fault = cur_fault;
                end
                result_q.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int mode, left;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(16, 96);
            while (left > 0) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req = 0;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    default: i_stall <= left[1];
                endcase
                left--;
            end
        end
    end

    function automatic void add(logic [1:0] cmd, logic [2:0] ch, logic [1:0] sel,
                                logic [31:0] wd, logic [31:0] mw);
        stim_q.push_back('{cmd, ch, sel, wd, mw, $urandom, 1'b0, '0, 1'b0});
    endfunction

    function automatic void add_typed(logic [1:0] cmd, logic [2:0] ch, logic [1:0] sel,
                                      logic [31:0] wd, logic [31:0] rd, logic flt);
        stim_q.push_back('{cmd, ch, sel, wd, $urandom, $urandom, 1'b1, rd, flt});
    endfunction

    function automatic void add_noise();
        logic [1:0] cmd, sel;
        logic [31:0] wd;
        cmd = 2'($urandom);
        sel = 2'($urandom);
        wd = $urandom;
        if (cmd == dcs_pkg::CMD_WRITE && sel == dcs_pkg::SEL_CTRL) wd[24] = 1'b0;
        add(cmd, 3'($urandom), sel, wd, $urandom);
    endfunction

    function automatic logic [31:0] ctrl_word(logic dir, logic back, logic [1:0] sync,
                                              logic trig);
        logic [31:0] wd;
        wd = $urandom;
        wd[0] = dir;
        wd[1] = back;
        wd[10:9] = sync;
        wd[24] = 1'b1;
        wd[28] = trig;
        return wd;
    endfunction

    function automatic void build_random();
        int kind, steps, nodes, cnt;
        logic [2:0] ch;
        logic [15:0] lo, hi;
        logic [1:0] sync;
        logic dir;
        logic [31:0] hdr;
        while (stim_q.size() < RANDOM_ITEMS + 25) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                ch = $urandom_range(0, 1) ? dcs_pkg::CH_GPU : dcs_pkg::CH_OTC;
                lo = 16'($urandom_range(0, 6));
                hi = 16'($urandom_range(0, 3));
                sync = 2'($urandom_range(0, 1));
                dir = ch == dcs_pkg::CH_GPU ? 1'($urandom) : ($urandom_range(0, 7) == 0);
                add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_BASE, $urandom, $urandom);
                add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_BLOCK, {hi, lo}, $urandom);
                add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_CTRL,
                    ctrl_word(dir, 1'($urandom), sync, $urandom_range(0, 4) != 0), $urandom);
                steps = (sync == 2'd1 ? lo * hi : lo) + $urandom_range(0, 2);
                repeat (steps) begin
                    case ($urandom_range(0, 11))
                        0: add(dcs_pkg::CMD_READ, 3'($urandom), 2'($urandom), $urandom,
                               $urandom);
                        1: add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_CTRL, $urandom, $urandom);
                        2: add(dcs_pkg::CMD_WRITE, 3'($urandom_range(0, 6)),
                               2'($urandom_range(0, 2)),
                               ctrl_word(1'($urandom), 1'($urandom), 2'd0, 1'b1), $urandom);
                        default: ;
                    endcase
                    add(dcs_pkg::CMD_STEP, 3'($urandom), 2'($urandom), $urandom, $urandom);
                end
            end else if (kind <= 5) begin
                add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GPU, dcs_pkg::SEL_BASE, $urandom,
                    $urandom);
                add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GPU, dcs_pkg::SEL_CTRL,
                    ctrl_word(1'b1, 1'($urandom), 2'd2, 1'($urandom)), $urandom);
                add(dcs_pkg::CMD_STEP, 3'($urandom), 2'($urandom), $urandom, $urandom);
                nodes = $urandom_range(1, 4);
                for (int n = 0; n < nodes; n++) begin
                    cnt = $urandom_range(0, 4);
                    hdr = $urandom;
                    hdr[31:24] = 8'(cnt);
                    hdr[23] = n == nodes - 1;
                    repeat (cnt == 0 ? 1 : cnt + 1) begin
                        if ($urandom_range(0, 9) == 0)
                            add(dcs_pkg::CMD_READ, 3'($urandom), 2'($urandom), $urandom,
                                $urandom);
                        add(dcs_pkg::CMD_STEP, 3'($urandom), 2'($urandom), $urandom, hdr);
                    end
                end
            end else if (kind == 6) begin
                add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_IRQ,
                    $urandom & ($urandom_range(0, 3) == 0 ? 32'hffffffff : 32'hffff7fff),
                    $urandom);
            end else if (kind == 7) begin
                ch = 3'($urandom_range(0, 6));
                add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_BLOCK, {16'($urandom_range(0, 2)),
                    16'($urandom_range(0, 3))}, $urandom);
                add(dcs_pkg::CMD_WRITE, ch, dcs_pkg::SEL_CTRL,
                    ctrl_word(1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom)),
                    $urandom);
                repeat ($urandom_range(0, 8))
                    add(dcs_pkg::CMD_STEP, 3'($urandom), 2'($urandom), $urandom, $urandom);
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 6)) add_noise();
            end else begin
                repeat ($urandom_range(1, 4))
                    add(dcs_pkg::CMD_READ, 3'($urandom), 2'($urandom), $urandom, $urandom);
            end
        end
    endfunction

    initial begin
        int idx, burst, gap;
        t_item it;
        for (int c = 0; c < dcs_pkg::NUM_CHANNELS; c++) begin
            chan_base[c] = '0;
            chan_block[c] = '0;
            chan_ctl[c] = '0;
        end
        irq_en = '0;
        irq_flag = '0;
        irq_fm = '0;
        prim_reg = dcs_pkg::PRIMARY_RST;
        run_ch = '0;
        run_phase = dcs_pkg::PH_IDLE;
        run_addr = '0;
        run_left = '0;
        run_hdr = '0;

        add_typed(dcs_pkg::CMD_READ, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_PRIMARY, '0,
                  dcs_pkg::PRIMARY_RST, 1'b0);
        add_typed(dcs_pkg::CMD_READ, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_IRQ, '0, '0, 1'b0);
        add_typed(dcs_pkg::CMD_READ, CH_ZERO, dcs_pkg::SEL_BASE, '0, '0, 1'b0);
        add_typed(dcs_pkg::CMD_READ, CH_FIVE, dcs_pkg::SEL_CTRL, '0, '0, 1'b0);
        add_typed(dcs_pkg::CMD_READ, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_CTRL, '0, '0, 1'b0);
        add_typed(dcs_pkg::CMD_READ, CH_ONE, SEL_UNUSED, '0, '0, 1'b0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_IRQ, 32'h00ff0000, '0);
        add(dcs_pkg::CMD_WRITE, CH_ZERO, dcs_pkg::SEL_BLOCK, 32'h00010004, '0);
        add_typed(dcs_pkg::CMD_WRITE, CH_ZERO, dcs_pkg::SEL_CTRL, 32'h11000000, '0, 1'b1);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_OTC, dcs_pkg::SEL_BLOCK, 32'h00000003, '0);
        add_typed(dcs_pkg::CMD_WRITE, dcs_pkg::CH_OTC, dcs_pkg::SEL_CTRL, 32'h11000001, '0,
                  1'b1);
        add_typed(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GPU, dcs_pkg::SEL_CTRL, 32'h01000400, '0,
                  1'b1);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GPU, dcs_pkg::SEL_CTRL, 32'h01000600, '0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_OTC, dcs_pkg::SEL_BASE, 32'h00000100, '0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_OTC, dcs_pkg::SEL_BLOCK, 32'h00000004, '0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_OTC, dcs_pkg::SEL_CTRL, 32'h11000002, '0);
        repeat (5) add(dcs_pkg::CMD_STEP, '0, '0, '0, '0);
        add(CMD_NOP, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_PRIMARY, 32'hffffffff, '0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GPU, dcs_pkg::SEL_CTRL, 32'hffffffff, '0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_PRIMARY, 32'hffffffff, '0);
        add_typed(dcs_pkg::CMD_READ, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_PRIMARY, '0,
                  32'hffffffff, 1'b0);
        add(dcs_pkg::CMD_WRITE, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_IRQ, 32'hffffffff, '0);
        add(dcs_pkg::CMD_READ, dcs_pkg::CH_GLOBAL, dcs_pkg::SEL_IRQ, '0, '0);
        build_random();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < stim_q.size()) begin
            burst = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            while (burst > 0 && idx < stim_q.size()) begin
                if (idx == 800) hold_req = 1;
                if (idx == 1400) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (result_q.size() != 0) @(posedge i_clk);
                end
                it = stim_q[idx];
                i_command <= it.cmd;
                i_channel <= it.ch;
                i_reg_select <= it.sel;
                i_write_data <= it.wd;
                i_mem_word <= it.mw;
                i_gpu_word <= it.gw;
                cur_typed <= it.typed;
                cur_rdata <= it.typed_rdata;
                cur_fault <= it.typed_fault;
                i_valid <= 1'b1;
                do @(posedge i_clk); while (o_stall);
                idx++;
                burst--;
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
